// ===== sv/descriptor_checksum_macros.svh =====
// Assertion macros for the descriptor checksum block.
// Used by descriptor_checksum.sv; expects i_clk and i_rst_n in scope.
`ifndef DESCRIPTOR_CHECKSUM_MACROS_SVH
`define DESCRIPTOR_CHECKSUM_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define DCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition must never be true outside reset
`define DCS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/dcs_pkg.sv =====
// Package for the descriptor checksum block: beat types, tables, polymod step.
// No dependencies; imported by every module of the block.
`default_nettype none

package dcs_pkg;

    localparam int POLY_W  = 40;
    localparam int SYM_W   = 5;
    localparam int N_GEN   = 5;
    localparam int N_OUT   = 8;
    localparam int ROM_N   = 95;

    localparam logic [POLY_W-1:0] POLY_INIT = 40'h1;

    localparam logic [POLY_W-1:0] GEN_TERMS [N_GEN] = '{
        40'hf5dee51989, 40'ha9fdca3312, 40'h1bab10e32d,
        40'h3706b1677a, 40'h644d626ffd
    };

    // position + 1 for each printable character 0x20..0x7E; 0 marks invalid
    localparam logic [6:0] POS_ROM [ROM_N] = '{
        7'h5f,7'h3c,7'h5d,7'h5c,7'h1d,7'h1e,7'h33,7'h10,7'h0b,7'h0c,7'h12,7'h34,
        7'h0f,7'h35,7'h36,7'h11,7'h01,7'h02,7'h03,7'h04,7'h05,7'h06,7'h07,7'h08,
        7'h09,7'h0a,7'h1c,7'h37,7'h38,7'h39,7'h3a,7'h3b,7'h1b,7'h53,7'h54,7'h55,
        7'h56,7'h57,7'h58,7'h59,7'h5a,7'h21,7'h22,7'h23,7'h24,7'h25,7'h26,7'h27,
        7'h28,7'h29,7'h2a,7'h2b,7'h2c,7'h2d,7'h2e,7'h2f,7'h30,7'h31,7'h32,7'h0d,
        7'h5e,7'h0e,7'h3d,7'h3e,7'h5b,7'h13,7'h14,7'h15,7'h16,7'h17,7'h18,7'h19,
        7'h1a,7'h41,7'h42,7'h43,7'h44,7'h45,7'h46,7'h47,7'h48,7'h49,7'h4a,7'h4b,
        7'h4c,7'h4d,7'h4e,7'h4f,7'h50,7'h51,7'h52,7'h1f,7'h3f,7'h20,7'h40
    };

    localparam logic [8*32-1:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_present;
        logic       last_char;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] checksum_char;
        logic       error;
        logic       last_of_run;
    } t_out_beat;

    // End-of-string snapshot handed from the absorber to the finisher
    typedef struct packed {
        logic [POLY_W-1:0] poly;
        logic [4:0]        accum;
        logic [1:0]        count;
        logic              bad;
    } t_job;

    typedef enum logic [1:0] {
        FIN_IDLE,
        FIN_RUN,
        FIN_EMIT
    } t_fin_state;

    // One polymod round: shift in a 5-bit symbol, reduce by the generator
    function automatic logic [POLY_W-1:0] feed_symbol(input logic [POLY_W-1:0] reg_in,
                                                      input logic [SYM_W-1:0]  sym);
        logic [SYM_W-1:0]  top;
        logic [POLY_W-1:0] nxt;
        top = reg_in[POLY_W-1 -: SYM_W];
        nxt = {reg_in[POLY_W-SYM_W-1:0], sym};
        for (int b = 0; b < N_GEN; b++) begin
            if (top[b]) begin
                nxt = nxt ^ GEN_TERMS[b];
            end
        end
        return nxt;
    endfunction

    // Position ROM lookup; 0 for non-printable or unlisted codes
    function automatic logic [6:0] pos_lookup(input logic [7:0] code);
        logic [6:0] idx;
        idx = 7'(code - 8'h20);
        if (code < 8'h20 || code > 8'h7e) begin
            return 7'd0;
        end
        return POS_ROM[idx];
    endfunction

    function automatic logic [7:0] charset_char(input logic [SYM_W-1:0] sym);
        logic [4:0] rev;
        rev = 5'd31 - sym;
        return CHARSET[{rev, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== sv/dcs_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat of type T.
// Depends on nothing; payload types come from dcs_pkg at the instance.
`default_nettype none

interface dcs_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/descriptor_checksum.sv =====
// Descriptor checksum engine: top level joining absorber and finisher.
// Depends on dcs_pkg, dcs_stream_if, dcs_absorb, dcs_finish and the macro header.
//
// Usage:
//   i_in carries one character beat per cycle (char_code, char_present,
//   last_char). A beat with last_char closes the string; its own character,
//   if present, is taken in first. o_out carries the result beats: eight
//   checksum characters, most significant first, last_of_run on the eighth,
//   or one error beat if the string held an invalid character.
//   Throughput: one character beat per cycle while i_in.ready is high. The first
//   checksum beat follows the job slot register, the class flush and the eight
//   zero rounds, run two per cycle; an error beat goes from the job slot
//   straight to the output. Characters of the next string keep flowing
//   while a checksum streams out; a second end beat waits in the job slot,
//   and i_in.ready drops only while that slot is full and the finisher busy.
//   A stalled receiver holds the current result beat steady.
//   Reset (synchronous, active low) clears the polymod state, the job slot
//   and the finisher; no beat is lost once reset is released.
`default_nettype none
`include "descriptor_checksum_macros.svh"

module descriptor_checksum (
    input  wire          i_clk,
    input  wire          i_rst_n,
    dcs_stream_if.sink   i_in,
    dcs_stream_if.source o_out
);
    import dcs_pkg::*;

    t_job w_job;
    logic w_job_valid;
    logic w_fin_idle;

    dcs_absorb u_absorb (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_fin_idle  (w_fin_idle),
        .o_job       (w_job),
        .o_job_valid (w_job_valid)
    );

    dcs_finish u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_idle      (w_fin_idle),
        .o_out       (o_out)
    );

    // Error beat always closes the run and carries no character
    `DCS_ASSERT(a_err_beat, (o_out.valid && o_out.data.error) |-> (o_out.data.last_of_run && o_out.data.checksum_char == 8'd0), "error beat malformed")
    // Finisher returns to idle after the closing beat of a run
    `DCS_ASSERT(a_run_gap, (o_out.valid && o_out.ready && o_out.data.last_of_run) |=> !o_out.valid, "result beat right after run end")
    // Input back-pressure only comes from a full job slot
    `DCS_NEVER(a_ready_src, !i_in.ready && !w_job_valid, "input stalled with empty job slot")
    // A waiting job is picked up whenever the finisher is idle
    `DCS_ASSERT(a_job_take, (w_job_valid && w_fin_idle && !(i_in.valid && i_in.data.last_char)) |=> !w_fin_idle, "idle finisher skipped a job")

endmodule

`default_nettype wire

// ===== sv/dcs_absorb.sv =====
// Character absorber: position lookup, polymod and class-group update per beat.
// Depends on dcs_pkg and dcs_stream_if; hands end-of-string jobs to dcs_finish.
`default_nettype none

module dcs_absorb (
    input  wire             i_clk,
    input  wire             i_rst_n,
    dcs_stream_if.sink      i_in,
    input  wire             i_fin_idle,
    output dcs_pkg::t_job   o_job,
    output logic            o_job_valid
);
    import dcs_pkg::*;

    logic [POLY_W-1:0] r_poly, n_poly;
    logic [4:0]        r_accum, n_accum;
    logic [1:0]        r_count, n_count;
    logic              r_bad, n_bad;
    t_job              r_job;
    logic              r_job_valid;

    logic              w_accept;
    logic              w_take;
    logic [6:0]        w_rom;
    logic [6:0]        w_pos;
    logic [POLY_W-1:0] w_poly1;
    logic [6:0]        w_acc_wide;
    logic [4:0]        w_acc1;
    logic [1:0]        w_cnt1;

    // Job slot frees when the finisher picks it up this cycle
    assign i_in.ready = !r_job_valid || i_fin_idle;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_take     = w_accept && i_in.data.char_present && !r_bad;

    // Symbol and class digit of the incoming character
    assign w_rom      = pos_lookup(i_in.data.char_code);
    assign w_pos      = 7'(w_rom - 7'd1);
    assign w_poly1    = feed_symbol(r_poly, w_pos[4:0]);
    assign w_acc_wide = 7'(7'(r_accum) * 7'd3) + 7'(w_pos[6:5]);
    assign w_acc1     = w_acc_wide[4:0];
    assign w_cnt1     = 2'(r_count + 2'd1);

    // Next state after taking the character (before any end handling)
    always_comb begin
        n_poly  = r_poly;
        n_accum = r_accum;
        n_count = r_count;
        n_bad   = r_bad;
        if (w_take) begin
            if (w_rom == 7'd0) begin
                n_bad = 1'b1;
            end else if (w_cnt1 == 2'd3) begin
                n_poly  = feed_symbol(w_poly1, w_acc1);
                n_accum = 5'd0;
                n_count = 2'd0;
            end else begin
                n_poly  = w_poly1;
                n_accum = w_acc1;
                n_count = w_cnt1;
            end
        end
    end

    // Running state; an end beat starts the next string from reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly  <= POLY_INIT;
            r_accum <= 5'd0;
            r_count <= 2'd0;
            r_bad   <= 1'b0;
        end else if (w_accept && i_in.data.last_char) begin
            r_poly  <= POLY_INIT;
            r_accum <= 5'd0;
            r_count <= 2'd0;
            r_bad   <= 1'b0;
        end else begin
            r_poly  <= n_poly;
            r_accum <= n_accum;
            r_count <= n_count;
            r_bad   <= n_bad;
        end
    end

    // End-of-string job slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
        end else if (w_accept && i_in.data.last_char) begin
            r_job_valid <= 1'b1;
        end else if (i_fin_idle) begin
            r_job_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.data.last_char) begin
            r_job.poly  <= n_poly;
            r_job.accum <= n_accum;
            r_job.count <= n_count;
            r_job.bad   <= n_bad;
        end
    end

    assign o_job       = r_job;
    assign o_job_valid = r_job_valid;

endmodule

`default_nettype wire

// ===== sv/dcs_finish.sv =====
// Finisher: class flush, eight zero rounds, final XOR and checksum streaming, or a lone error beat.
// Depends on dcs_pkg and dcs_stream_if; takes jobs from dcs_absorb.
`default_nettype none

module dcs_finish (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  dcs_pkg::t_job   i_job,
    input  wire             i_job_valid,
    output logic            o_idle,
    dcs_stream_if.source    o_out
);
    import dcs_pkg::*;

    t_fin_state        r_state, n_state;
    logic [POLY_W-1:0] r_poly, n_poly;
    logic              r_err, n_err;
    logic [2:0]        r_step, n_step;
    logic              w_last;

    assign w_last = r_err || (r_step == 3'd7);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FIN_IDLE;
            r_step  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Working register and error flag
    always_ff @(posedge i_clk) begin
        r_poly <= n_poly;
        r_err  <= n_err;
    end

    // Next state and outputs
    always_comb begin
        n_state                  = r_state;
        n_poly                   = r_poly;
        n_err                    = r_err;
        n_step                   = r_step;
        o_idle                   = 1'b0;
        o_out.valid              = 1'b0;
        o_out.data.checksum_char = r_err ? 8'd0 : charset_char(r_poly[POLY_W-1 -: SYM_W]);
        o_out.data.error         = r_err;
        o_out.data.last_of_run   = w_last;
        unique case (r_state)
            FIN_IDLE: begin
                o_idle = 1'b1;
                if (i_job_valid) begin
                    n_err  = i_job.bad;
                    n_step = 3'd0;
                    if (i_job.bad) begin
                        n_state = FIN_EMIT;
                    end else begin
                        n_state = FIN_RUN;
                        n_poly  = (i_job.count != 2'd0) ?
                                  feed_symbol(i_job.poly, i_job.accum) : i_job.poly;
                    end
                end
            end
            FIN_RUN: begin
                // two zero rounds per cycle, eight zero rounds in all
                n_poly = feed_symbol(feed_symbol(r_poly, 5'd0), 5'd0);
                n_step = 3'(r_step + 3'd1);
                if (r_step == 3'd3) begin
                    n_poly  = n_poly ^ POLY_INIT;
                    n_step  = 3'd0;
                    n_state = FIN_EMIT;
                end
            end
            FIN_EMIT: begin
                o_out.valid = 1'b1;
                if (o_out.ready) begin
                    if (w_last) begin
                        n_state = FIN_IDLE;
                        n_step  = 3'd0;
                    end else begin
                        n_poly = {r_poly[POLY_W-SYM_W-1:0], {SYM_W{1'b0}}};
                        n_step = 3'(r_step + 3'd1);
                    end
                end
            end
            default: begin
                n_state = FIN_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== bench/tb_descriptor_checksum.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for descriptor_checksum: random and directed descriptor strings.
// Depends on dcs_pkg, dcs_stream_if and descriptor_checksum; predicts every result beat.

module tb_descriptor_checksum;
    import dcs_pkg::*;

    localparam int CLK_HALF_NS     = 10;
    localparam int TIMEOUT_NS      = 10_000_000;
    localparam int MAX_SHOWN       = 10;
    localparam int DRAIN_CYCLES    = 20;
    localparam int N_PHASES        = 4;
    localparam int ITEMS_PER_PHASE = 100;

    // Per phase: sender idle and receiver stall, percent of cycles
    localparam int PHASE_SEND_IDLE [N_PHASES]  = '{0, 72, 0, 15};
    localparam int PHASE_SINK_STALL [N_PHASES] = '{0, 0, 72, 15};

    // BCH generator terms of the descriptor checksum
    localparam logic [39:0] GEN_POLY [5] = '{
        40'hf5dee51989, 40'ha9fdca3312, 40'h1bab10e32d,
        40'h3706b1677a, 40'h644d626ffd
    };

    // Last five entries of the input character order (backtick, hash, quote, backslash, space)
    localparam logic [7:0] ORDER_TAIL [5] = '{8'h60, 8'h23, 8'h22, 8'h5c, 8'h20};

    logic i_clk;
    logic i_rst_n;

    dcs_stream_if #(.T(t_in_beat))  in_ch ();
    dcs_stream_if #(.T(t_out_beat)) out_ch ();

    descriptor_checksum dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Character beats waiting to be driven, result beats waiting to arrive
    t_in_beat  pending_chars [$];
    t_out_beat expected_chars [$];

    // Checksum state of the string being absorbed
    logic [39:0] sum_reg;
    logic [4:0]  grp_acc;
    logic [1:0]  grp_cnt;
    logic        str_bad;

    // Position + 1 of each character in the input order; 0 = not allowed
    logic [6:0] char_pos [256];
    string      out_alphabet = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

    int  send_idle_pct;
    int  sink_stall_pct;
    bit  in_taken;
    int  items_queued;
    int  chars_accepted;
    int  checksum_runs;
    int  error_runs;
    int  beats_checked;
    int  fail_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        #TIMEOUT_NS;
        $display("CHECK FAILED");
        $finish;
    end

    // One polymod round: shift in a 5-bit symbol, reduce by the generator
    function automatic logic [39:0] polymod_round(input logic [39:0] acc,
                                                  input logic [4:0]  sym);
        logic [39:0] nxt;
        nxt = {acc[34:0], sym};
        for (int b = 0; b < 5; b++) begin
            if (acc[35 + b]) begin
                nxt = nxt ^ GEN_POLY[b];
            end
        end
        return nxt;
    endfunction

    task automatic clear_string_state();
        sum_reg = 40'h1;
        grp_acc = '0;
        grp_cnt = '0;
        str_bad = 1'b0;
    endtask

    // Absorb one accepted beat; on an end beat queue the result beats it causes
    task automatic absorb_and_predict(input t_in_beat beat);
        logic [6:0]  pos;
        logic [39:0] fin;
        t_out_beat   res;
        if (beat.char_present && !str_bad) begin
            pos = char_pos[beat.char_code];
            if (pos == 7'd0) begin
                str_bad = 1'b1;
            end else begin
                pos     = pos - 7'd1;
                sum_reg = polymod_round(sum_reg, pos[4:0]);
                grp_acc = 5'(int'(grp_acc) * 3 + int'(pos[6:5]));
                grp_cnt = grp_cnt + 2'd1;
                if (grp_cnt == 2'd3) begin
                    sum_reg = polymod_round(sum_reg, grp_acc);
                    grp_acc = '0;
                    grp_cnt = '0;
                end
            end
        end
        if (beat.last_char) begin
            if (str_bad) begin
                res.checksum_char = 8'h00;
                res.error         = 1'b1;
                res.last_of_run   = 1'b1;
                expected_chars.push_back(res);
                error_runs++;
            end else begin
                fin = sum_reg;
                if (grp_cnt != 2'd0) begin
                    fin = polymod_round(fin, grp_acc);
                end
                repeat (8) fin = polymod_round(fin, 5'd0);
                fin = fin ^ 40'h1;
                for (int i = 0; i < 8; i++) begin
                    res.checksum_char = out_alphabet[int'(fin[5*(7-i) +: 5])];
                    res.error         = 1'b0;
                    res.last_of_run   = (i == 7);
                    expected_chars.push_back(res);
                end
                checksum_runs++;
            end
            clear_string_state();
        end
    endtask

    task automatic push_beat(input logic [7:0] code, input logic present, input logic last);
        t_in_beat b;
        b.char_code    = code;
        b.char_present = present;
        b.last_char    = last;
        pending_chars.push_back(b);
        if (present || last) begin
            items_queued++;
        end
    endtask

    task automatic note_failure(input string what, input t_out_beat exp_b, input t_out_beat got_b);
        fail_count++;
        if (fail_count <= MAX_SHOWN) begin
            $display("%0t: %s: exp char=%h err=%b last=%b, got char=%h err=%b last=%b",
                     $realtime, what, exp_b.checksum_char, exp_b.error, exp_b.last_of_run,
                     got_b.checksum_char, got_b.error, got_b.last_of_run);
        end
    endtask

    // Driver: new beat or idle at the falling edge, hold while not accepted
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_ch.valid <= 1'b1;
                in_ch.data  <= pending_chars[0];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Monitor: predict on accepted input beats, check accepted result beats
    always @(posedge i_clk) begin
        t_in_beat  sent;
        t_out_beat got;
        t_out_beat want;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            in_taken = in_ch.valid && in_ch.ready;
            if (in_taken) begin
                sent = pending_chars.pop_front();
                absorb_and_predict(in_ch.data);
                if (sent.char_present) begin
                    chars_accepted++;
                end
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_chars.size() == 0) begin
                    note_failure("unexpected beat", '0, got);
                end else begin
                    want = expected_chars.pop_front();
                    beats_checked++;
                    if (got.checksum_char !== want.checksum_char ||
                        got.error !== want.error ||
                        got.last_of_run !== want.last_of_run) begin
                        note_failure("mismatch", want, got);
                    end
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        string order_a;
        string order_b;
        int    start_count;
        int    str_len;
        int    bad_at;
        bit    end_on_char;
        logic [7:0] code;

        order_a = "0123456789()[],'/*abcdefgh@:$%{}";
        order_b = "IJKLMNOPQRSTUVWXYZ&+-.;<=>?!^_|~ijklmnopqrstuvwxyzABCDEFGH";
        foreach (char_pos[i]) char_pos[i] = 7'd0;
        for (int i = 0; i < order_a.len(); i++) begin
            char_pos[order_a[i]] = 7'(i + 1);
        end
        for (int i = 0; i < order_b.len(); i++) begin
            char_pos[order_b[i]] = 7'(order_a.len() + i + 1);
        end
        for (int i = 0; i < 5; i++) begin
            char_pos[ORDER_TAIL[i]] = 7'(order_a.len() + order_b.len() + i + 1);
        end

        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        items_queued   = 0;
        chars_accepted = 0;
        checksum_runs  = 0;
        error_runs     = 0;
        beats_checked  = 0;
        fail_count     = 0;
        in_taken       = 1'b0;
        clear_string_state();

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            send_idle_pct  = PHASE_SEND_IDLE[ph];
            sink_stall_pct = PHASE_SINK_STALL[ph];
            if (ph == 0) begin
                // empty string: end beat alone
                push_beat(8'hff, 1'b0, 1'b1);
                // lowest printable code, ending on its own beat
                push_beat(8'h20, 1'b1, 1'b1);
                // highest printable code, then a separate end beat
                push_beat(8'h7e, 1'b1, 1'b0);
                push_beat(8'h00, 1'b0, 1'b1);
                // exactly one full class group
                push_beat("a", 1'b1, 1'b0);
                push_beat("b", 1'b1, 1'b0);
                push_beat("c", 1'b1, 1'b1);
                // partial group flush with an idle beat in the middle
                push_beat("A", 1'b1, 1'b0);
                push_beat("#", 1'b1, 1'b0);
                push_beat(8'h80, 1'b0, 1'b0);
                push_beat(8'h60, 1'b1, 1'b0);
                push_beat("Z", 1'b1, 1'b1);
                // invalid control code, later characters ignored
                push_beat(8'h1f, 1'b1, 1'b0);
                push_beat("x", 1'b1, 1'b0);
                push_beat(8'h55, 1'b0, 1'b1);
                // invalid code on the end beat itself
                push_beat(8'h7f, 1'b1, 1'b1);
                // both extremes of the code range
                push_beat(8'h00, 1'b1, 1'b0);
                push_beat(8'hff, 1'b1, 1'b0);
                push_beat(8'haa, 1'b0, 1'b1);
                // lone idle beat, nothing expected
                push_beat(8'h7f, 1'b0, 1'b0);
            end

            // Random strings: mostly short and valid, some long, some broken
            start_count = items_queued;
            while (items_queued - start_count < ITEMS_PER_PHASE) begin
                str_len = ($urandom_range(9) == 0) ? $urandom_range(48, 11)
                                                   : $urandom_range(10);
                bad_at = (str_len > 0 && $urandom_range(7) == 0) ? $urandom_range(str_len - 1)
                                                                 : -1;
                end_on_char = (str_len > 0) && ($urandom_range(1) == 1);
                for (int i = 0; i < str_len; i++) begin
                    if ($urandom_range(29) == 0) begin
                        push_beat(8'($urandom_range(255)), 1'b0, 1'b0);
                    end
                    if (i == bad_at) begin
                        code = $urandom_range(1) ? 8'($urandom_range(31))
                                                 : 8'($urandom_range(255, 127));
                    end else begin
                        code = 8'($urandom_range(126, 32));
                    end
                    push_beat(code, 1'b1, end_on_char && (i == str_len - 1));
                end
                if (!end_on_char) begin
                    push_beat(8'($urandom_range(255)), 1'b0, 1'b1);
                end
            end

            while (pending_chars.size() != 0 || expected_chars.size() != 0) begin
                @(posedge i_clk);
            end
        end

        // Let any stray beat show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d character beats in %0d idling phases.",
                 chars_accepted, N_PHASES);
        $display("%0d checksum runs and %0d error runs, %0d result beats checked.",
                 checksum_runs, error_runs, beats_checked);
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
